// ----- hw/rtl/mi3_pkg.sv -----
package mi3_pkg;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int COF_W      = PROD_W + 1;
    localparam int DPROD_W    = DATA_W + COF_W;
    localparam int DET_W      = DPROD_W + 2;
    localparam int DMAG_W     = DET_W - 1;
    localparam int FRAC_SHIFT = 24;
    localparam int NUM_W      = COF_W + FRAC_SHIFT;
    localparam int Q_W        = 33;
    localparam int OUT_W      = 32;
    localparam int LIMIT_W    = 24;
    localparam int N_ELEM     = 9;
    localparam int FRONT_STG  = 5;
    localparam int LATENCY    = FRONT_STG + Q_W + 1;

    localparam logic [Q_W-1:0] Q_POS_MAX = Q_W'(33'h0_7FFF_FFFF);
    localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(33'h0_8000_0000);
    localparam logic [OUT_W-1:0] OUT_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_SAT = 32'h8000_0000;

    typedef logic [Q_W-1:0] t_quot;
endpackage

// ----- hw/rtl/mi3_div_lane.sv -----
module mi3_div_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [mi3_pkg::COF_W-1:0]  i_mag,
    input  logic [mi3_pkg::DMAG_W-1:0] i_dmag,
    input  logic                       i_neg,
    output mi3_pkg::t_quot             o_quot,
    output logic                       o_ovf,
    output logic                       o_neg
);
    import mi3_pkg::*;

    logic [NUM_W-1:0]  r_rem  [Q_W+1];
    logic [Q_W-1:0]    r_q    [Q_W+1];
    logic [DMAG_W-1:0] r_d    [Q_W+1];
    logic              r_ovf  [Q_W+1];
    logic              r_neg  [Q_W+1];

    // quotient needs more than Q_W bits when num >= dmag * 2^Q_W
    always_comb begin
        r_rem[0] = {i_mag, FRAC_SHIFT'(0)};
        r_q[0]   = '0;
        r_d[0]   = i_dmag;
        r_ovf[0] = DMAG_W'(i_mag[COF_W-1:Q_W-FRAC_SHIFT]) >= i_dmag;
        r_neg[0] = i_neg;
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int J = Q_W - 1 - k;
        logic fits;
        assign fits = (r_rem[k] >> J) >= NUM_W'(r_d[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= fits ? r_rem[k] - (NUM_W'(r_d[k]) << J) : r_rem[k];
                r_q[k+1]   <= {r_q[k][Q_W-2:0], fits};
                r_d[k+1]   <= r_d[k];
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign o_quot = r_q[Q_W];
    assign o_ovf  = r_ovf[Q_W];
    assign o_neg  = r_neg[Q_W];
endmodule

// ----- hw/rtl/matrix_inverse_3x3.sv -----
// 3x3 matrix inverse by adjugate, Q8.8 in, Q16.16 out.
// Input channel: i_valid / o_ready with i_m00..i_m22 and i_last_in.
// Output channel: o_valid / i_ready with o_inv00..o_inv22, o_singular,
// o_saturated and o_last_out (the item's last marker).
// Throughput: one matrix per cycle unless the receiver stalls. A result passes
// through 39 register stages: 5 stages of products, cofactors and determinant,
// 33 stages of a restoring divider (one quotient bit per stage, nine lanes in
// parallel), and one output stage with sign and clamp.
// A matrix whose |det| is at most det_limit gives zeros and o_singular.
// det_limit is written through i_cfg_wr_en / i_cfg_wr_data; it resets to 0.
// Reset (synchronous, active low) empties the pipeline; items in flight are
// dropped.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_ready drops; nothing is lost or repeated. o_ready is high whenever
// the output register is empty or being taken.
module matrix_inverse_3x3 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m00,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m01,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m02,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m10,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m11,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m12,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m20,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m21,
    input  logic signed [mi3_pkg::DATA_W-1:0] i_m22,
    input  logic                              i_last_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv00,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv01,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv02,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv10,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv11,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv12,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv20,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv21,
    output logic signed [mi3_pkg::OUT_W-1:0]  o_inv22,
    output logic                              o_singular,
    output logic                              o_saturated,
    output logic                              o_last_out,
    input  logic                              i_cfg_wr_en,
    input  logic [mi3_pkg::LIMIT_W-1:0]       i_cfg_wr_data
);
    import mi3_pkg::*;

    logic en;
    logic [LIMIT_W-1:0] r_det_limit;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] r_last;

    logic signed [PROD_W-1:0]  r_pa [N_ELEM];
    logic signed [PROD_W-1:0]  r_pb [N_ELEM];
    logic signed [DATA_W-1:0]  r_row1 [3];
    logic signed [DATA_W-1:0]  r_row2 [3];
    logic signed [COF_W-1:0]   r_cof2 [N_ELEM];
    logic signed [COF_W-1:0]   r_cof3 [N_ELEM];
    logic signed [COF_W-1:0]   r_cof4 [N_ELEM];
    logic signed [DPROD_W-1:0] r_dp [3];
    logic signed [DET_W-1:0]   r_det;
    logic [COF_W-1:0]          r_mag [N_ELEM];
    logic                      r_neg [N_ELEM];
    logic [DMAG_W-1:0]         r_dmag;
    logic [Q_W:0]              r_sing;

    logic [DMAG_W-1:0] dmag;
    t_quot             quot [N_ELEM];
    logic              ovf  [N_ELEM];
    logic              qneg [N_ELEM];
    logic [OUT_W-1:0]  n_res [N_ELEM];
    logic [N_ELEM-1:0] sat;
    logic [OUT_W-1:0]  r_res [N_ELEM];
    logic              r_sat_out;

    // the whole pipeline holds while a result waits
    assign en      = !r_vld[LATENCY-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_limit <= '0;
        end else if (i_cfg_wr_en) begin
            r_det_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[LATENCY-2:0], i_last_in};
            // stage 1: cofactor products
            r_pa[0] <= i_m11 * i_m22;  r_pb[0] <= i_m12 * i_m21;
            r_pa[1] <= i_m02 * i_m21;  r_pb[1] <= i_m01 * i_m22;
            r_pa[2] <= i_m01 * i_m12;  r_pb[2] <= i_m02 * i_m11;
            r_pa[3] <= i_m12 * i_m20;  r_pb[3] <= i_m10 * i_m22;
            r_pa[4] <= i_m00 * i_m22;  r_pb[4] <= i_m02 * i_m20;
            r_pa[5] <= i_m02 * i_m10;  r_pb[5] <= i_m00 * i_m12;
            r_pa[6] <= i_m10 * i_m21;  r_pb[6] <= i_m11 * i_m20;
            r_pa[7] <= i_m01 * i_m20;  r_pb[7] <= i_m00 * i_m21;
            r_pa[8] <= i_m00 * i_m11;  r_pb[8] <= i_m01 * i_m10;
            r_row1[0] <= i_m00;
            r_row1[1] <= i_m01;
            r_row1[2] <= i_m02;
            // stage 2: cofactors
            for (int i = 0; i < N_ELEM; i++) begin
                r_cof2[i] <= COF_W'(r_pa[i]) - COF_W'(r_pb[i]);
            end
            r_row2 <= r_row1;
            // stage 3: expansion along row 0
            r_dp[0] <= r_row2[0] * r_cof2[0];
            r_dp[1] <= r_row2[1] * r_cof2[3];
            r_dp[2] <= r_row2[2] * r_cof2[6];
            r_cof3  <= r_cof2;
            // stage 4: determinant
            r_det  <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
            r_cof4 <= r_cof3;
            // stage 5: magnitudes and signs for the divider
            r_dmag <= dmag;
            for (int i = 0; i < N_ELEM; i++) begin
                r_mag[i] <= r_cof4[i][COF_W-1] ? COF_W'(-r_cof4[i]) : COF_W'(r_cof4[i]);
                r_neg[i] <= r_cof4[i][COF_W-1] ^ r_det[DET_W-1];
            end
            r_sing <= {r_sing[Q_W-1:0], dmag <= DMAG_W'(r_det_limit)};
            // output stage
            r_res     <= n_res;
            r_sat_out <= !r_sing[Q_W] && (|sat);
        end
    end

    assign dmag = r_det[DET_W-1] ? DMAG_W'(-r_det) : DMAG_W'(r_det);

    for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
        mi3_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_mag  (r_mag[i]),
            .i_dmag (r_dmag),
            .i_neg  (r_neg[i]),
            .o_quot (quot[i]),
            .o_ovf  (ovf[i]),
            .o_neg  (qneg[i])
        );

        always_comb begin
            sat[i] = ovf[i] || (qneg[i] ? (quot[i] > Q_NEG_MAX) : (quot[i] > Q_POS_MAX));
            if (r_sing[Q_W]) begin
                n_res[i] = '0;
            end else if (sat[i]) begin
                n_res[i] = qneg[i] ? OUT_NEG_SAT : OUT_POS_SAT;
            end else begin
                n_res[i] = qneg[i] ? OUT_W'(-quot[i]) : quot[i][OUT_W-1:0];
            end
        end
    end

    logic r_sing_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing_out <= r_sing[Q_W];
        end
    end

    assign o_valid     = r_vld[LATENCY-1];
    assign o_last_out  = r_last[LATENCY-1];
    assign o_singular  = r_sing_out;
    assign o_saturated = r_sat_out;
    assign o_inv00 = r_res[0];
    assign o_inv01 = r_res[1];
    assign o_inv02 = r_res[2];
    assign o_inv10 = r_res[3];
    assign o_inv11 = r_res[4];
    assign o_inv12 = r_res[5];
    assign o_inv20 = r_res[6];
    assign o_inv21 = r_res[7];
    assign o_inv22 = r_res[8];
endmodule

// ----- hw/rtl/mi3_checker.sv -----
module mi3_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic                             o_ready,
    input logic                             o_singular,
    input logic                             o_saturated,
    input logic signed [mi3_pkg::OUT_W-1:0] o_inv00,
    input logic signed [mi3_pkg::OUT_W-1:0] o_inv11,
    input logic signed [mi3_pkg::OUT_W-1:0] o_inv22
);
    import mi3_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_sing_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated)
        else $error("singular item flagged saturated");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_inv00 == 0 && o_inv11 == 0 && o_inv22 == 0)
        else $error("singular item has nonzero result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result right after reset");
endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (.*);

// ----- tb/matrix_inverse_3x3_test.sv -----
module matrix_inverse_3x3_test;
    import mi3_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic                     last;
    } t_mat;

    typedef struct {
        logic [OUT_W-1:0] inv [N_ELEM];
        logic             singular;
        logic             saturated;
        logic             last;
    } t_inv;

    localparam int STALL_LIMIT = 2000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic signed [DATA_W-1:0] i_m [N_ELEM];
    logic i_last_in = 0;
    logic o_valid;
    logic i_ready = 0;
    logic signed [OUT_W-1:0] o_inv [N_ELEM];
    logic o_singular, o_saturated, o_last_out;
    logic i_cfg_wr_en = 0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;

    t_mat pending_mats[$];
    t_inv expected_invs[$];
    logic [LIMIT_W-1:0] det_limit_shadow = '0;
    int errors = 0;
    int n_sent = 0;
    int n_got = 0;
    int n_singular = 0;
    int n_saturated = 0;
    int send_wait = 0;
    int take_wait = 0;
    int idle_cycles = 0;
    bit idling_on = 1;

    initial for (int i = 0; i < N_ELEM; i++) i_m[i] = '0;

    always #10 i_clk = ~i_clk;

    matrix_inverse_3x3 uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_m00(i_m[0]), .i_m01(i_m[1]), .i_m02(i_m[2]),
        .i_m10(i_m[3]), .i_m11(i_m[4]), .i_m12(i_m[5]),
        .i_m20(i_m[6]), .i_m21(i_m[7]), .i_m22(i_m[8]),
        .i_last_in(i_last_in),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_inv00(o_inv[0]), .o_inv01(o_inv[1]), .o_inv02(o_inv[2]),
        .o_inv10(o_inv[3]), .o_inv11(o_inv[4]), .o_inv12(o_inv[5]),
        .o_inv20(o_inv[6]), .o_inv21(o_inv[7]), .o_inv22(o_inv[8]),
        .o_singular(o_singular), .o_saturated(o_saturated), .o_last_out(o_last_out),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data)
    );

    // Adjugate inverse with exact integer arithmetic.
    function automatic t_inv invert(t_mat m, logic [LIMIT_W-1:0] limit);
        t_inv r;
        longint a, b, c, d, e, f, g, h, k, det, dmag, cmag, q;
        longint adj [N_ELEM];
        bit neg;
        a = m.m00; b = m.m01; c = m.m02;
        d = m.m10; e = m.m11; f = m.m12;
        g = m.m20; h = m.m21; k = m.m22;
        adj[0] = e*k - f*h; adj[1] = c*h - b*k; adj[2] = b*f - c*e;
        adj[3] = f*g - d*k; adj[4] = a*k - c*g; adj[5] = c*d - a*f;
        adj[6] = d*h - e*g; adj[7] = b*g - a*h; adj[8] = a*e - b*d;
        det = a*adj[0] + b*adj[3] + c*adj[6];
        dmag = det < 0 ? -det : det;
        r.saturated = 0;
        r.last = m.last;
        r.singular = dmag <= longint'(limit);
        for (int i = 0; i < N_ELEM; i++) begin
            if (r.singular) begin
                r.inv[i] = '0;
            end else begin
                cmag = adj[i] < 0 ? -adj[i] : adj[i];
                // cmag < 2^33, so the shifted numerator fits in 57 bits
                q = (cmag <<< FRAC_SHIFT) / dmag;
                neg = (adj[i] < 0) != (det < 0);
                if (neg && q > 64'h8000_0000) begin
                    q = 64'h8000_0000;
                    r.saturated = 1;
                end else if (!neg && q > 64'h7FFF_FFFF) begin
                    q = 64'h7FFF_FFFF;
                    r.saturated = 1;
                end
                r.inv[i] = neg ? OUT_W'(-q) : OUT_W'(q);
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rand_elem(int mode);
        case (mode)
            0: return DATA_W'($urandom);
            1: return DATA_W'($urandom_range(0, 1023)) - 16'sd512;
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return DATA_W'($urandom_range(0, 7)) - 16'sd3;
        endcase
    endfunction

    function automatic t_mat rand_mat();
        t_mat m;
        int mode;
        logic [DATA_W-1:0] v [N_ELEM];
        mode = $urandom_range(0, 3);
        for (int i = 0; i < N_ELEM; i++) v[i] = rand_elem($urandom_range(0, 9) == 0 ? 0 : mode);
        // make some rows dependent to hit singular and near-singular cases
        if ($urandom_range(0, 7) == 0) for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
        if ($urandom_range(0, 15) == 0) begin
            v = '{default: 16'sd0};
            v[0] = rand_elem(0); v[4] = rand_elem(0); v[8] = rand_elem(0);
        end
        m = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 1'b0};
        m.last = 1'($urandom_range(0, 1));
        return m;
    endfunction

    function automatic t_mat make_mat(int a, int b, int c, int d, int e, int f,
                                      int g, int h, int k, bit last);
        t_mat m;
        m = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h), 16'(k), last};
        return m;
    endfunction

    // Driver: hold valid and payload until the item is taken.
    always @(posedge i_clk) begin
        t_mat m;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_invs.push_back(invert({i_m[0], i_m[1], i_m[2], i_m[3], i_m[4],
                                                i_m[5], i_m[6], i_m[7], i_m[8], i_last_in},
                                               det_limit_shadow));
                n_sent++;
                send_wait <= idling_on ? $urandom_range(0, 11) : 0;
            end
            if ((!i_valid || o_ready) && send_wait == 0 && pending_mats.size() > 0
                    && !(i_valid && o_ready && idling_on)) begin
                m = pending_mats.pop_front();
                {i_m[0], i_m[1], i_m[2], i_m[3], i_m[4], i_m[5], i_m[6], i_m[7], i_m[8],
                 i_last_in} <= m;
                i_valid <= 1;
            end else if (i_valid && o_ready) begin
                i_valid <= 0;
            end else if (!i_valid && send_wait > 0 && !(i_valid && o_ready)) begin
                send_wait <= send_wait - 1;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        t_inv x;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_got++;
                if (expected_invs.size() == 0) begin
                    $error("result with no matrix pending");
                    errors++;
                end else begin
                    x = expected_invs.pop_front();
                    for (int i = 0; i < N_ELEM; i++)
                        if (o_inv[i] !== x.inv[i]) begin
                            $error("inv%0d%0d expected %0d got %0d", i / 3, i % 3,
                                   $signed(x.inv[i]), o_inv[i]);
                            errors++;
                        end
                    if (o_singular !== x.singular) begin
                        $error("singular expected %0b got %0b", x.singular, o_singular);
                        errors++;
                    end
                    if (o_saturated !== x.saturated) begin
                        $error("saturated expected %0b got %0b", x.saturated, o_saturated);
                        errors++;
                    end
                    if (o_last_out !== x.last) begin
                        $error("last_out expected %0b got %0b", x.last, o_last_out);
                        errors++;
                    end
                    n_singular += x.singular;
                    n_saturated += x.saturated;
                end
                take_wait = idling_on ? $urandom_range(0, 11) : 0;
                i_ready <= take_wait == 0;
            end else if (take_wait > 0) begin
                take_wait--;
                i_ready <= take_wait == 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    // Watchdog: count cycles without any accepted item.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_mats.size() > 0 || i_valid || expected_invs.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        i_cfg_wr_data <= v;
        i_cfg_wr_en <= 1;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        det_limit_shadow = v;
    endtask

    initial begin
        logic [LIMIT_W-1:0] limits [5];
        limits = '{24'h0, 24'hFFFFFF, 24'h1, 24'h1000, 24'h0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // identity, extremes, singular, saturation, sign combinations
        pending_mats.push_back(make_mat(256, 0, 0, 0, 256, 0, 0, 0, 256, 1));
        pending_mats.push_back(make_mat(-256, 0, 0, 0, 256, 0, 0, 0, 256, 0));
        pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        pending_mats.push_back(make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_mats.push_back(make_mat(-1, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_mats.push_back(make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 1));
        pending_mats.push_back(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, 0));
        pending_mats.push_back(make_mat(-32768, -32768, -32768, -32768, -32768, -32768,
                                        -32768, -32768, -32768, 1));
        pending_mats.push_back(make_mat(32767, -32768, 32767, -32768, 32767, -32768,
                                        -32768, -32768, 32767, 0));
        pending_mats.push_back(make_mat(-32768, 32767, 0, 32767, -32768, 32767,
                                        0, 32767, -32768, 1));
        pending_mats.push_back(make_mat(1, 2, 3, 4, 5, 6, 7, 8, 9, 0));
        pending_mats.push_back(make_mat(256, 512, 0, 0, 256, 768, -256, 0, 512, 1));
        pending_mats.push_back(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0));
        pending_mats.push_back(make_mat(0, 1, 0, 0, 0, 1, 1, 0, 0, 1));
        pending_mats.push_back(make_mat(32767, 32767, 0, 0, 32767, 32767, 32767, 0, 32767, 0));
        drain();

        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p] == 0 && p > 0 ? 24'($urandom) : limits[p]);
            idling_on = p != 2;
            for (int i = 0; i < 300; i++) pending_mats.push_back(rand_mat());
            drain();
        end

        $display("checked %0d matrices in, %0d results out (%0d singular, %0d clamped)",
                 n_sent, n_got, n_singular, n_saturated);
        if (errors == 0 && expected_invs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_div_lane.sv
hw/rtl/matrix_inverse_3x3.sv
hw/rtl/mi3_checker.sv
tb/matrix_inverse_3x3_test.sv
